FILE: design/gpm_pkg.sv
// Package for the glob pattern matcher: sizes, command codes and character codes.
// No dependencies.
package gpm_pkg;
    localparam int MAX_CHARS = 63;
    localparam int IDX_W = 6;
    localparam int LEN_W = 7;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_PAT  = 2'd0;
    localparam t_cmd CMD_NAME = 2'd1;
    localparam t_cmd CMD_EVAL = 2'd2;

    localparam logic CFG_CASE = 1'b0;
    localparam logic CFG_PATH = 1'b1;

    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_QUERY  = 8'd63;
    localparam logic [7:0] CH_OPEN   = 8'd91;
    localparam logic [7:0] CH_CLOSE  = 8'd93;
    localparam logic [7:0] CH_DASH   = 8'd45;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_SLASH  = 8'd47;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] char_value;
    } t_in_word;

    typedef struct packed {
        logic matched;
        logic truncated;
    } t_out_word;

    typedef struct packed {
        logic       index;
        logic [7:0] data;
    } t_cfg_word;
endpackage

FILE: design/gpm_if.sv
// Valid/ready channel interfaces for the glob pattern matcher.
// Depends on gpm_pkg.
interface gpm_in_if;
    logic              valid;
    logic              ready;
    gpm_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gpm_out_if;
    logic               valid;
    logic               ready;
    gpm_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gpm_cfg_if;
    logic               valid;
    logic               ready;
    gpm_pkg::t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/glob_pattern_match_top.sv
// Glob pattern matcher top level: string stores and the evaluation sequencer.
// Depends on gpm_pkg and the channel interfaces in gpm_if.sv.
//
// Usage. Input words carry a command and a character. Command 0 appends
// the character to the pattern, command 1 to the name; zero bytes are
// ignored and a full store drops the byte and sets the truncation flag.
// Command 2 evaluates and then clears both strings; it yields one output
// word with matched and truncated. Command 3 does nothing.
// An evaluate word is worked by a sequencer that reads pattern and name
// bytes from the stores and does one compare per step. Input ready is low
// while evaluating and while a result waits in the output register, so a
// stalled receiver holds off the input. Configuration writes (index 0
// case_sensitive, 1 path_mode) are always accepted. After reset both
// strings are empty, case_sensitive is 1 and path_mode 0.
module glob_pattern_match_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gpm_in_if.sink    in_ch,
    gpm_out_if.source out_ch,
    gpm_cfg_if.sink   cfg_ch
);
    import gpm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;  // read pattern byte at p
    localparam logic [3:0] S_DISP  = 4'd2;  // decide by pattern byte
    localparam logic [3:0] S_SCAN  = 4'd3;  // star: find run end
    localparam logic [3:0] S_CMP   = 4'd4;  // star: compare pat[s+k]
    localparam logic [3:0] S_CMPN  = 4'd5;  // star: compare name[pos+k]
    localparam logic [3:0] S_SETN  = 4'd6;  // set: load name char
    localparam logic [3:0] S_SET   = 4'd7;  // set: walk elements
    localparam logic [3:0] S_SKIP  = 4'd8;  // set: skip to close
    localparam logic [3:0] S_LIT   = 4'd9;  // literal compare
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [7:0] pat_mem  [MAX_CHARS];
    logic [7:0] name_mem [MAX_CHARS];

    logic [3:0]       r_state, n_state;
    logic [LEN_W-1:0] r_plen, r_nlen;
    logic             r_ovf, r_case, r_path;
    logic             r_out_valid, r_matched, r_trunc;
    logic             n_out_valid, n_matched;
    logic [LEN_W-1:0] r_p, n_p, r_n, n_n, r_s, n_s, r_pos, n_pos, r_k, n_k, r_f, n_f;
    logic [7:0]       r_c, n_c, r_nc, n_nc;
    logic [7:0]       r_w0, n_w0, r_w1, n_w1, r_w2, n_w2; // window pat[f..f+2]
    logic             r_found, n_found;
    logic [1:0]       r_wfill, n_wfill;

    // Read ports on pattern and name, addressed by the sequencer.
    logic [LEN_W-1:0] pa, na;
    logic [7:0]       pa_raw, na_raw;
    logic             pa_ok, na_ok;
    logic [7:0]       pv, nv;

    function automatic logic [7:0] fold_c(input logic [7:0] c, input logic cs);
        if (!cs && c >= 8'd97 && c <= 8'd122) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] map_c(input logic [7:0] c, input logic pm);
        if (pm && (c == CH_BSLASH || c == CH_COLON)) begin
            return CH_SLASH;
        end
        return c;
    endfunction

    logic acc_in;
    assign in_ch.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign acc_in       = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = '{matched: r_matched, truncated: r_trunc};

    // Reads are registered: the data appears in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (acc_in && in_ch.data.cmd == CMD_PAT && in_ch.data.char_value != 8'd0
            && r_plen < LEN_W'(MAX_CHARS)) begin
            pat_mem[r_plen[IDX_W-1:0]] <= in_ch.data.char_value;
        end
        if (acc_in && in_ch.data.cmd == CMD_NAME && in_ch.data.char_value != 8'd0
            && r_nlen < LEN_W'(MAX_CHARS)) begin
            name_mem[r_nlen[IDX_W-1:0]] <= in_ch.data.char_value;
        end
        pa_raw <= pat_mem[na < LEN_W'(MAX_CHARS) ? na[IDX_W-1:0] : '0];
        na_raw <= name_mem[pa < LEN_W'(MAX_CHARS) ? pa[IDX_W-1:0] : '0];
        pa_ok  <= na < r_plen;
        na_ok  <= pa < r_nlen;
    end
    // na addresses the pattern and pa the name.
    assign pv = pa_ok ? map_c(pa_raw, r_path) : 8'd0;
    assign nv = na_ok ? map_c(na_raw, r_path) : 8'd0;

    logic pv_end;
    assign pv_end = (pv == 8'd0) || (pv == CH_STAR) || (pv == CH_QUERY);

    always_comb begin
        n_state = r_state; n_p = r_p; n_n = r_n; n_s = r_s; n_pos = r_pos;
        n_k = r_k; n_f = r_f; n_c = r_c; n_nc = r_nc; n_found = r_found;
        n_w0 = r_w0; n_w1 = r_w1; n_w2 = r_w2; n_wfill = r_wfill;
        n_out_valid = r_out_valid; n_matched = r_matched;
        na = r_p; pa = r_n;
        if (r_out_valid && out_ch.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (acc_in && in_ch.data.cmd == CMD_EVAL) begin
                    n_p = '0; n_n = '0; na = '0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                na = r_p;
                n_state = S_DISP;
            end
            S_DISP: begin
                // pv is pat[p]; the pattern port has pat[p+1] on request.
                n_c = pv;
                if (pv == 8'd0) begin
                    n_matched = 1'b1; n_state = S_DONE;
                end else if (pv == CH_STAR) begin
                    n_p = r_p + LEN_W'(1); n_s = r_p + LEN_W'(1);
                    na = r_p + LEN_W'(1);
                    n_state = S_SCAN;
                end else if (pv == CH_QUERY) begin
                    n_p = r_p + LEN_W'(1); n_n = r_n + LEN_W'(1);
                    na = r_p + LEN_W'(1);
                    n_state = S_FETCH;
                end else if (pv == CH_OPEN) begin
                    n_state = S_SETN;
                    pa = r_n;
                    na = r_p + LEN_W'(1);
                end else begin
                    pa = r_n;
                    n_state = S_LIT;
                end
            end
            S_LIT: begin
                na = r_p;
                if (fold_c(r_c, r_case) != fold_c(nv, r_case)) begin
                    n_matched = 1'b0; n_state = S_DONE;
                end else begin
                    n_p = r_p + LEN_W'(1); n_n = r_n + LEN_W'(1);
                    na = r_p + LEN_W'(1);
                    n_state = S_FETCH;
                end
            end
            S_SCAN: begin
                if (pv_end) begin
                    if (r_p == r_s) begin
                        na = r_p; n_state = S_FETCH;
                    end else begin
                        n_pos = r_n; n_k = '0;
                        na = r_s; pa = r_n;
                        n_state = S_CMP;
                    end
                end else begin
                    n_p = r_p + LEN_W'(1); na = r_p + LEN_W'(1);
                end
            end
            S_CMP: begin
                // Run of length p-s at name pos; stop if it cannot fit.
                if (r_pos + (r_p - r_s) > r_nlen) begin
                    n_matched = 1'b0; n_state = S_DONE;
                end else if (r_k == r_p - r_s) begin
                    n_n = r_pos + r_k; na = r_p; n_state = S_FETCH;
                end else begin
                    n_c = pv; pa = r_pos + r_k; n_state = S_CMPN;
                end
            end
            S_CMPN: begin
                if (fold_c(r_c, r_case) == fold_c(nv, r_case)) begin
                    n_k = r_k + LEN_W'(1);
                    na = r_s + r_k + LEN_W'(1);
                end else begin
                    n_pos = r_pos + LEN_W'(1); n_k = '0; na = r_s;
                end
                n_state = S_CMP;
            end
            S_SETN: begin
                // pv = pat[p+1], nv = name[n]
                if (pv == CH_OPEN) begin
                    n_p = r_p + LEN_W'(1); na = r_p + LEN_W'(1);
                    n_state = S_FETCH;
                end else begin
                    n_nc = fold_c(nv, r_case);
                    n_found = 1'b0;
                    n_w0 = pv; n_f = r_p + LEN_W'(1);
                    n_wfill = 2'd1;
                    na = r_p + LEN_W'(2);
                    n_state = S_SET;
                end
            end
            S_SET: begin
                // Fill window w0..w2 plus lookahead pv = pat[f+wfill].
                if (r_wfill == 2'd1) begin
                    n_w1 = pv; n_wfill = 2'd2; na = r_f + LEN_W'(2);
                end else if (r_wfill == 2'd2) begin
                    n_w2 = pv; n_wfill = 2'd3; na = r_f + LEN_W'(3);
                end else begin
                    // w0=pat[f], w1=f+1, w2=f+2, pv=f+3
                    if (r_w0 == 8'd0 || r_found || (r_w0 == CH_CLOSE && r_w1 != CH_CLOSE)) begin
                        if (!r_found) begin
                            n_matched = 1'b0; n_state = S_DONE;
                        end else begin
                            na = r_f; n_state = S_SKIP;
                            n_wfill = 2'd0;
                        end
                    end else if (r_w1 == CH_DASH && r_w2 != 8'd0 &&
                                 (r_w2 != CH_CLOSE || pv == CH_CLOSE)) begin
                        if (r_nc >= fold_c(r_w0, r_case) && r_nc <= fold_c(r_w2, r_case)) begin
                            n_found = 1'b1;
                        end
                        n_f = r_f + LEN_W'(3);
                        n_w0 = pv; n_wfill = 2'd1; na = r_f + LEN_W'(4);
                    end else begin
                        if (fold_c(r_w0, r_case) == r_nc) begin
                            n_found = 1'b1;
                        end
                        n_f = r_f + LEN_W'(1);
                        n_w0 = r_w1; n_w1 = r_w2; n_w2 = pv;
                        na = r_f + LEN_W'(4);
                    end
                end
            end
            S_SKIP: begin
                // wfill 0: pv = pat[f]; then w0 = pat[f], pv = pat[f+1].
                if (r_wfill == 2'd0) begin
                    n_w0 = pv; n_wfill = 2'd1; na = r_f + LEN_W'(1);
                end else if (r_w0 != 8'd0 && (r_w0 != CH_CLOSE || pv == CH_CLOSE)) begin
                    n_f = r_f + LEN_W'(1); n_w0 = pv; na = r_f + LEN_W'(2);
                end else begin
                    n_p = r_f + LEN_W'(1); n_n = r_n + LEN_W'(1);
                    na = r_f + LEN_W'(1);
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_plen <= '0; r_nlen <= '0; r_ovf <= 1'b0;
            r_case <= 1'b1; r_path <= 1'b0; r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_ch.valid) begin
                if (cfg_ch.data.index == CFG_CASE) r_case <= cfg_ch.data.data[0];
                else r_path <= cfg_ch.data.data[0];
            end
            if (acc_in && in_ch.data.char_value != 8'd0) begin
                if (in_ch.data.cmd == CMD_PAT) begin
                    if (r_plen < LEN_W'(MAX_CHARS)) r_plen <= r_plen + LEN_W'(1);
                    else r_ovf <= 1'b1;
                end else if (in_ch.data.cmd == CMD_NAME) begin
                    if (r_nlen < LEN_W'(MAX_CHARS)) r_nlen <= r_nlen + LEN_W'(1);
                    else r_ovf <= 1'b1;
                end
            end
            if (r_state == S_DONE) begin
                r_plen <= '0; r_nlen <= '0; r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p; r_n <= n_n; r_s <= n_s; r_pos <= n_pos; r_k <= n_k; r_f <= n_f;
        r_c <= n_c; r_nc <= n_nc; r_found <= n_found; r_w0 <= n_w0; r_w1 <= n_w1;
        r_w2 <= n_w2; r_wfill <= n_wfill;
        r_matched <= n_matched;
        if (r_state == S_DONE) r_trunc <= r_ovf;
    end
endmodule

FILE: design/gpm_checker.sv
// Port-level checker for the glob pattern matcher, bound to the top level.
// Depends on gpm_pkg and on the channel interfaces of the top level.
module gpm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic [1:0] in_cmd,
    input logic out_valid,
    input logic out_ready,
    input logic [1:0] out_data
);
    import gpm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output word changed while stalled.");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("Input ready while a result waits.");
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_cmd == CMD_EVAL |=> !in_ready)
        else $error("Input ready straight after an evaluate word.");
    a_append_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_cmd != CMD_EVAL && !out_valid |=> !out_valid)
        else $error("Result word without an evaluate word.");
endmodule

bind glob_pattern_match_top gpm_checker u_gpm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.data.cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
